// ===== hdl/drp_pkg.sv =====
// Shared codes, register map and reset values for the dirty-rectangle push decider.
package drp_pkg;

    // Operation carried in the input word's tuser.
    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_FORCE = 2'd1,
        OP_END   = 2'd2
    } t_op;

    // Verdict carried in the result word's tuser.
    typedef enum logic [1:0] {
        VD_SKIP    = 2'd0,
        VD_FULL    = 2'd1,
        VD_PARTIAL = 2'd2
    } t_verdict;

    // Register indexes (byte address = 4 * index).
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_PCT    = 2'd2
    } t_reg_idx;

    localparam int RST_WIDTH  = 320;
    localparam int RST_HEIGHT = 240;
    localparam int RST_PCT    = 85;
    localparam int PCT_SCALE  = 100;
    localparam int PCT_BITS   = 7;

endpackage

// ===== hdl/dirty_rect_push_decider.sv =====
// Top level of the dirty-rectangle push decider: mark clipping, box tracking, frame verdict.
//
// Usage:
//   Input words (s_axis) carry one operation each, selected by tuser: mark a rectangle,
//   request a full refresh, or end a frame. Marks are clipped to the display and grow a
//   bounding box; refresh requests are held for the next frame. Each end of frame yields
//   exactly one result word (m_axis): skip, full push or partial push, plus the region
//   and the sent size. Marks and refresh requests yield no result word.
//   Display size and full-push threshold sit in APB registers at 0x0, 0x4 and 0x8;
//   write them only while the block is idle.
// Throughput: one word per cycle while s_axis_tready is high. An end of frame is taken
//   into the input register, and the verdict is computed in one pass from there into the
//   result register, which drives m_axis_tvalid.
// Threshold: display area times percent is precomputed in two registered steps, so
//   s_axis_tready drops at a register write, in the cycle after it, and in the first
//   cycle after reset.
// Backpressure: marks and refresh requests always drain from the input register; an end
//   of frame waits there while a stalled result word holds, and s_axis_tready stays low
//   until the receiver takes the result.
// Reset (synchronous, active low): registers return to 320 x 240 and 85 percent, the
//   box clears, the first frame is forced to a full push, and both registers empty.
module dirty_rect_push_decider
    import drp_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // stream in
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: rect_x, rect_y, rect_w, rect_h (COORD_BITS+1 each, signed), any_layers
    input  logic [((4*(COORD_BITS+1)+1+7)/8)*8-1:0] s_axis_tdata,
    // tuser: op
    input  logic [1:0]                s_axis_tuser,
    // stream out
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata: push_left, push_top, push_right, push_bottom, sent_width, sent_height
    output logic [((6*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: verdict
    output logic [1:0]                m_axis_tuser,
    // APB configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int C         = COORD_BITS;
    localparam int SC        = C + 1;          // signed input coordinate
    localparam int EW        = C + 2;          // room for x + w
    localparam int OUT_W     = 6 * C;
    localparam int OUT_TDW   = ((OUT_W + 7) / 8) * 8;
    localparam int AREA_W    = 2 * C;
    localparam int PROD_W    = AREA_W + PCT_BITS;

    // ---------------------------------------------------------------- config
    logic [C-1:0]        r_width;
    logic [C-1:0]        r_height;
    logic [PCT_BITS-1:0] r_pct;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= C'(RST_WIDTH);
            r_height <= C'(RST_HEIGHT);
            r_pct    <= PCT_BITS'(RST_PCT);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:  r_width  <= pwdata[C-1:0];
                REG_HEIGHT: r_height <= pwdata[C-1:0];
                REG_PCT:    r_pct    <= pwdata[PCT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_PCT:    prdata = 32'(r_pct);
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------- threshold
    // Display area, then area times percent, each registered from its source.
    logic [AREA_W-1:0] r_disp;
    logic [PROD_W-1:0] r_thresh;
    logic              r_cfg_settle;

    always_ff @(posedge i_clk) begin
        r_disp   <= {{C{1'b0}}, r_width} * {{C{1'b0}}, r_height};
        r_thresh <= {{PCT_BITS{1'b0}}, r_disp} * {{AREA_W{1'b0}}, r_pct};
    end

    // Hold the input off until the threshold has caught up with the registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_settle <= 1'b1;
        end else begin
            r_cfg_settle <= cfg_wr;
        end
    end

    // ---------------------------------------------------------- stage flow
    logic r0_valid, r_out_valid;
    logic room0, room_out;
    logic s0_go, s0_end_go;
    logic in_take;

    assign room_out = !r_out_valid || m_axis_tready;

    // ---------------------------------------------------------- input stage
    logic                 r0_end;
    logic                 r0_mark;
    logic                 r0_force;
    logic signed [SC-1:0] r0_x, r0_y, r0_w, r0_h;
    logic                 r0_layers;

    // Marks and refresh requests always drain; an end of frame waits for a free slot.
    assign s0_go         = r0_valid && (!r0_end || room_out);
    assign s0_end_go     = s0_go && r0_end;
    assign room0         = !r0_valid || s0_go;
    assign s_axis_tready = room0 && !r_cfg_settle && !cfg_wr;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (room0) begin
            r0_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r0_mark   <= (t_op'(s_axis_tuser) == OP_MARK);
            r0_force  <= (t_op'(s_axis_tuser) == OP_FORCE);
            r0_end    <= (t_op'(s_axis_tuser) == OP_END);
            r0_x      <= s_axis_tdata[SC-1:0];
            r0_y      <= s_axis_tdata[2*SC-1:SC];
            r0_w      <= s_axis_tdata[3*SC-1:2*SC];
            r0_h      <= s_axis_tdata[4*SC-1:3*SC];
            r0_layers <= s_axis_tdata[4*SC];
        end
    end

    // ---------------------------------------------------------- clip + box
    logic signed [EW-1:0] x0, y0, x1, y1, disp_w, disp_h;
    logic signed [EW-1:0] cx0, cy0, cx1, cy1;
    logic                 clip_hit;

    always_comb begin
        x0     = EW'(r0_x);
        y0     = EW'(r0_y);
        x1     = x0 + EW'(r0_w);
        y1     = y0 + EW'(r0_h);
        disp_w = signed'({2'b00, r_width});
        disp_h = signed'({2'b00, r_height});
        cx0    = (x0 < 0) ? '0 : x0;
        cy0    = (y0 < 0) ? '0 : y0;
        cx1    = (x1 > disp_w) ? disp_w : x1;
        cy1    = (y1 > disp_h) ? disp_h : y1;
        clip_hit = (cx0 < cx1) && (cy0 < cy1);
    end

    logic [C-1:0] r_box_left, r_box_top, r_box_right, r_box_bottom;
    logic [C-1:0] n_box_left, n_box_top, n_box_right, n_box_bottom;
    logic         r_box_marked, n_box_marked;
    logic         r_frame_forced, r_force_pending;
    logic [C-1:0] clip_l, clip_t, clip_r, clip_b;

    assign clip_l = cx0[C-1:0];
    assign clip_t = cy0[C-1:0];
    assign clip_r = cx1[C-1:0];
    assign clip_b = cy1[C-1:0];

    always_comb begin
        n_box_left   = r_box_left;
        n_box_top    = r_box_top;
        n_box_right  = r_box_right;
        n_box_bottom = r_box_bottom;
        n_box_marked = r_box_marked;
        if (s0_end_go) begin
            // new frame: empty box against the current display size
            n_box_left   = r_width;
            n_box_top    = r_height;
            n_box_right  = '0;
            n_box_bottom = '0;
            n_box_marked = 1'b0;
        end else if (s0_go && r0_mark && clip_hit) begin
            if (clip_l < r_box_left)   n_box_left   = clip_l;
            if (clip_t < r_box_top)    n_box_top    = clip_t;
            if (clip_r > r_box_right)  n_box_right  = clip_r;
            if (clip_b > r_box_bottom) n_box_bottom = clip_b;
            n_box_marked = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left      <= C'(RST_WIDTH);
            r_box_top       <= C'(RST_HEIGHT);
            r_box_right     <= '0;
            r_box_bottom    <= '0;
            r_box_marked    <= 1'b0;
            r_frame_forced  <= 1'b1;
            r_force_pending <= 1'b0;
        end else begin
            r_box_left   <= n_box_left;
            r_box_top    <= n_box_top;
            r_box_right  <= n_box_right;
            r_box_bottom <= n_box_bottom;
            r_box_marked <= n_box_marked;
            if (s0_end_go) begin
                r_frame_forced  <= r_force_pending;
                r_force_pending <= 1'b0;
            end else if (s0_go && r0_force) begin
                r_force_pending <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------- verdict
    logic [C-1:0]      box_dw, box_dh;
    logic [AREA_W-1:0] box_area;
    logic [PROD_W-1:0] box_scaled;
    logic              cover_full;

    always_comb begin
        box_dw     = (r_box_right >= r_box_left) ? r_box_right - r_box_left : '0;
        box_dh     = (r_box_bottom >= r_box_top) ? r_box_bottom - r_box_top : '0;
        box_area   = {{C{1'b0}}, box_dw} * {{C{1'b0}}, box_dh};
        box_scaled = {{PCT_BITS{1'b0}}, box_area} * PROD_W'(PCT_SCALE);
        cover_full = (box_scaled >= r_thresh);
    end

    t_verdict         r_out_verdict, n_out_verdict;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    always_comb begin
        if (!r_box_marked && !r0_layers) begin
            n_out_verdict = VD_SKIP;
            n_out_data    = '0;
        end else if (!r_box_marked || r_frame_forced || cover_full) begin
            n_out_verdict = VD_FULL;
            n_out_data    = {r_height, r_width, r_height, r_width,
                             {C{1'b0}}, {C{1'b0}}};
        end else begin
            n_out_verdict = VD_PARTIAL;
            n_out_data    = {box_dh, box_dw, r_box_bottom, r_box_right,
                             r_box_top, r_box_left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (room_out) begin
            r_out_valid <= s0_end_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_end_go) begin
            r_out_verdict <= n_out_verdict;
            r_out_data    <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_verdict;
    assign m_axis_tdata  = OUT_TDW'(r_out_data);

endmodule

// ===== hdl/drp_chk.sv =====
// Port-level checker for the dirty-rectangle push decider, bound to the top level.
module drp_chk
    import drp_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((6*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    input logic [1:0]                             m_axis_tuser
);

    localparam int C = COORD_BITS;

    logic [C-1:0] f_left, f_top, f_right, f_bottom, f_sw, f_sh;

    assign f_left   = m_axis_tdata[C-1:0];
    assign f_top    = m_axis_tdata[2*C-1:C];
    assign f_right  = m_axis_tdata[3*C-1:2*C];
    assign f_bottom = m_axis_tdata[4*C-1:3*C];
    assign f_sw     = m_axis_tdata[5*C-1:4*C];
    assign f_sh     = m_axis_tdata[6*C-1:5*C];

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // skipped frames carry an empty region
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == VD_SKIP) |-> (m_axis_tdata == '0))
        else $error("skip verdict with nonzero region");

    // full push starts at the origin and its size equals its far corner
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == VD_FULL) |->
            (f_left == '0) && (f_top == '0) && (f_sw == f_right) && (f_sh == f_bottom))
        else $error("full push region not anchored at origin");

    // partial push reports a non-empty box and its own size
    a_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == VD_PARTIAL) |->
            (f_right > f_left) && (f_bottom > f_top) &&
            (f_sw == f_right - f_left) && (f_sh == f_bottom - f_top))
        else $error("partial push size does not match its box");

endmodule

bind dirty_rect_push_decider drp_chk #(
    .COORD_BITS(COORD_BITS)
) u_drp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
